// ----- hdl/tahs_pkg.sv -----
// shared types and constants for the terrace aware heightmap smoothing block
package tahs_pkg;

    localparam int TAHS_MAX_WIDTH = 1024;

    // field widths
    localparam int GW_W   = 11;
    localparam int GH_W   = 16;
    localparam int STEP_W = 24;
    localparam int HV_W   = 32;
    localparam int CHG_W  = 31;
    localparam int CFG_DW = 24;

    // divider operand widths: numerator signed, divisor unsigned
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 29;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH   = 2'd0,
        REG_GRID_HEIGHT  = 2'd1,
        REG_TERRACE_STEP = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RD_CENTER = 2'd0,
        RD_LEFT   = 2'd1,
        RD_RIGHT  = 2'd2,
        RD_ABOVE  = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        DIV_BAND  = 2'd0,
        DIV_CHG   = 2'd1,
        DIV_QUANT = 2'd2
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RD_C,
        ST_RD_L,
        ST_RD_R,
        ST_RD_A,
        ST_BAND_GO,
        ST_BAND_WAIT,
        ST_SUM,
        ST_CHG_GO,
        ST_CHG_WAIT,
        ST_Q_GO,
        ST_Q_WAIT,
        ST_MUL,
        ST_EMIT,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    div_start;
        div_op_t div_op;
        logic    cap_band;
        logic    cap_sum;
        logic    cap_chg;
        logic    cap_q;
        logic    cap_fin;
        logic    emit;
        logic    advance;
    } tahs_cmd_t;

    typedef struct packed {
        logic drain;
        logic pending_zero;
        logic row_nonzero;
        logic kind;
        logic step_zero;
        logic div_done;
        logic out_free;
    } tahs_status_t;

endpackage

// ----- hdl/tahs_sample_if.sv -----
// sample channel: kind and height
interface tahs_sample_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] height_value;

    modport source (output valid, output kind, output height_value, input ready);
    modport sink (input valid, input kind, input height_value, output ready);
endinterface

// ----- hdl/tahs_result_if.sv -----
// result channel: smoothed height, frame peak change and frame end flag
interface tahs_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] smoothed_value;
    logic [30:0]        max_change;
    logic               frame_last;

    modport source (output valid, output smoothed_value, output max_change,
                    output frame_last, input ready);
    modport sink (input valid, input smoothed_value, input max_change,
                  input frame_last, output ready);
endinterface

// ----- hdl/tahs_cfg_if.sv -----
// configuration write channel
interface tahs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/tahs_div.sv -----
// bit-serial signed floor divider with non-negative remainder
module tahs_div
    import tahs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0]        den,
    output logic                     done,
    output logic signed [DIV_NW-1:0] quot,
    output logic [DIV_DW-1:0]        rem
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_NW-1:0] mag_reg;
    logic [DIV_DW-1:0] part_reg;
    logic [DIV_DW-1:0] den_reg;
    logic              neg_reg;
    logic signed [DIV_NW-1:0] quot_reg;
    logic [DIV_DW-1:0] rem_reg;

    logic [DIV_DW:0]   shifted;
    logic              fits;
    logic [DIV_DW:0]   part_sub;

    always_comb
    begin
        shifted  = {part_reg, mag_reg[DIV_NW-1]};
        fits     = shifted >= {1'b0, den_reg};
        part_sub = fits ? shifted - {1'b0, den_reg} : shifted;
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
            neg_reg  <= num[DIV_NW-1];
            den_reg  <= den;
            part_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg  <= {mag_reg[DIV_NW-2:0], fits};
            part_reg <= part_sub[DIV_DW-1:0];
        end
        else if (fin_reg)
        begin
            // floor toward minus infinity for negative numerators
            if (neg_reg && part_reg != '0)
            begin
                quot_reg <= $signed(~mag_reg);
                rem_reg  <= den_reg - part_reg;
            end
            else if (neg_reg)
            begin
                quot_reg <= $signed(-mag_reg);
                rem_reg  <= '0;
            end
            else
            begin
                quot_reg <= $signed(mag_reg);
                rem_reg  <= part_reg;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/tahs_datapath.sv -----
// row store, counters, configuration registers, arithmetic and output register
module tahs_datapath
    import tahs_pkg::*;
#(
    parameter int MAX_WIDTH = TAHS_MAX_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tahs_cmd_t           cmd,
    output tahs_status_t        status,
    input  logic                kind,
    input  logic signed [31:0]  height_value,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                res_ready,
    output logic                res_valid,
    output logic signed [31:0]  smoothed_value,
    output logic [CHG_W-1:0]    max_change,
    output logic                frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = CW + 1;

    // configuration and frame position
    logic [GW_W-1:0]   gw_reg;
    logic [GH_W-1:0]   gh_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     col_reg;
    logic [GH_W-1:0]   row_reg;
    logic [WW-1:0]     pend_reg;
    logic [CHG_W-1:0]  peak_reg;

    // item and operands
    logic               kind_reg;
    logic signed [31:0] sample_reg;
    logic signed [31:0] c_reg, l_reg, r_reg, a_reg;
    logic signed [32:0] lo_reg;
    logic signed [34:0] sum_reg;
    logic [2:0]         n_reg;
    logic signed [DIV_NW-1:0] q_reg;
    logic signed [31:0] fin_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [CHG_W-1:0]   out_chg_reg;
    logic               out_last_reg;

    logic signed [31:0] row_mem [2**AW];

    logic [WW-1:0]   eff_w;
    logic [GH_W-1:0] eff_h;
    logic            drain;
    logic            cpar;
    logic            has_left, has_right, has_above;
    logic            last_col;
    logic            last_out;
    logic            restart;
    logic [AW-1:0]   rd_addr;

    logic signed [31:0] nb [4];
    logic [3:0]         nb_ok;
    logic [3:0]         nb_use;
    logic signed [33:0] nb_d [4];
    logic signed [34:0] sum_next;
    logic [2:0]         n_next;

    logic [4:0]                den;
    logic signed [35:0]        cn;
    logic signed [36:0]        dev;
    logic [36:0]               adev;
    logic signed [37:0]        num;
    logic [DIV_DW-1:0]         den_step;
    logic signed [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]         div_den;
    logic                      div_done;
    logic signed [DIV_NW-1:0]  div_quot;
    logic [DIV_DW-1:0]         div_rem;
    logic [CHG_W-1:0]          chg_sat;
    logic signed [58:0]        prod;

    always_comb
    begin
        if (gw_reg == '0)
            eff_w = WW'(1);
        else if (32'(gw_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(gw_reg);
        eff_h     = (gh_reg == '0) ? GH_W'(1) : gh_reg;
        drain     = row_reg >= eff_h;
        cpar      = ~row_reg[0];
        has_left  = col_reg != '0;
        has_right = (WW'(col_reg) + WW'(1)) < eff_w;
        has_above = row_reg >= GH_W'(2);
        last_col  = (WW'(col_reg) + WW'(1)) >= eff_w;
        last_out  = pend_reg == WW'(1);
        restart   = cfg_valid && (cfg_index == REG_GRID_WIDTH
                    || cfg_index == REG_GRID_HEIGHT || cfg_index == REG_TERRACE_STEP);
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CENTER: rd_addr = {cpar, col_reg};
            RD_LEFT:   rd_addr = {cpar, col_reg - CW'(1)};
            RD_RIGHT:  rd_addr = {cpar, col_reg + CW'(1)};
            RD_ABOVE:  rd_addr = {~cpar, col_reg};
            default:   rd_addr = {cpar, col_reg};
        endcase
    end

    // row store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.advance && !drain)
            row_mem[{row_reg[0], col_reg}] <= sample_reg;
        if (cmd.rd_en)
        begin
            unique case (cmd.rd_sel)
                RD_CENTER: c_reg <= row_mem[rd_addr];
                RD_LEFT:   l_reg <= row_mem[rd_addr];
                RD_RIGHT:  r_reg <= row_mem[rd_addr];
                RD_ABOVE:  a_reg <= row_mem[rd_addr];
                default:   c_reg <= row_mem[rd_addr];
            endcase
        end
    end

    // neighbors that share the center's terrace band
    always_comb
    begin
        nb[0] = l_reg;
        nb[1] = r_reg;
        nb[2] = a_reg;
        nb[3] = sample_reg;
        nb_ok = {!drain, has_above, has_right, has_left};
        sum_next = 35'(c_reg);
        n_next   = 3'd1;
        for (int i = 0; i < 4; i++)
        begin
            nb_d[i]   = 34'(nb[i]) - 34'(lo_reg);
            nb_use[i] = nb_ok[i] && ((step_reg == '0)
                        || (!nb_d[i][33] && $unsigned(nb_d[i]) < 34'(step_reg)));
            if (nb_use[i])
            begin
                sum_next = sum_next + 35'(nb[i]);
                n_next   = n_next + 3'd1;
            end
        end
    end

    // blend operands: num = 3*c*n + 2*sum, den = 5*n
    always_comb
    begin
        den      = 5'(n_reg) * 5'd5;
        cn       = c_reg * $signed({1'b0, n_reg});
        dev      = 37'(sum_reg) - 37'(cn);
        adev     = dev[36] ? $unsigned(-dev) : $unsigned(dev);
        num      = (38'(cn) <<< 1) + 38'(cn) + (38'(sum_reg) <<< 1);
        den_step = DIV_DW'(den) * DIV_DW'(step_reg);
        unique case (cmd.div_op)
            DIV_BAND:
            begin
                div_num = DIV_NW'(c_reg);
                div_den = DIV_DW'(step_reg);
            end
            DIV_CHG:
            begin
                div_num = $signed(DIV_NW'({adev, 2'b00}) + DIV_NW'(den));
                div_den = DIV_DW'({den, 1'b0});
            end
            DIV_QUANT:
            begin
                if (step_reg == '0)
                begin
                    div_num = (DIV_NW'(num) <<< 1) + $signed(DIV_NW'(den));
                    div_den = DIV_DW'({den, 1'b0});
                end
                else
                begin
                    div_num = DIV_NW'(num);
                    div_den = den_step;
                end
            end
            default:
            begin
                div_num = DIV_NW'(c_reg);
                div_den = DIV_DW'(step_reg);
            end
        endcase
    end

    tahs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_comb
    begin
        chg_sat = (|div_quot[DIV_NW-1:CHG_W]) ? {CHG_W{1'b1}} : div_quot[CHG_W-1:0];
        prod    = $signed(q_reg[33:0]) * $signed({1'b0, step_reg});
    end

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            sample_reg <= height_value;
        end
        if (cmd.cap_band)
            lo_reg <= 33'(c_reg) - $signed({9'b0, div_rem[STEP_W-1:0]});
        if (cmd.cap_sum)
        begin
            sum_reg <= sum_next;
            n_reg   <= n_next;
        end
        if (cmd.cap_q)
            q_reg <= div_quot;
        if (cmd.cap_fin)
        begin
            if (step_reg == '0)
                fin_reg <= div_quot[31:0];
            else if (prod < -59'sd2147483648)
                fin_reg <= 32'sh8000_0000;
            else
                fin_reg <= prod[31:0];
        end
        if (cmd.emit)
        begin
            out_value_reg <= fin_reg;
            out_last_reg  <= drain && last_out;
            out_chg_reg   <= (drain && last_out) ? peak_reg : '0;
        end
    end

    // configuration, frame position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg        <= GW_W'(1);
            gh_reg        <= GH_W'(1);
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:   gw_reg   <= cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT:  gh_reg   <= cfg_data[GH_W-1:0];
                    REG_TERRACE_STEP: step_reg <= cfg_data[STEP_W-1:0];
                    default:          gw_reg   <= gw_reg;
                endcase
            end
            if (restart)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                pend_reg <= '0;
                peak_reg <= '0;
            end
            else
            begin
                if (cmd.cap_chg && chg_sat > peak_reg)
                    peak_reg <= chg_sat;
                if (cmd.advance)
                begin
                    if (drain)
                    begin
                        if (last_out)
                        begin
                            col_reg  <= '0;
                            row_reg  <= '0;
                            pend_reg <= '0;
                            peak_reg <= '0;
                        end
                        else
                        begin
                            pend_reg <= pend_reg - WW'(1);
                            col_reg  <= col_reg + CW'(1);
                        end
                    end
                    else if (last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + GH_W'(1);
                        if ((row_reg + GH_W'(1)) >= eff_h)
                            pend_reg <= eff_w;
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.drain        = drain;
        status.pending_zero = pend_reg == '0;
        status.row_nonzero  = row_reg != '0;
        status.kind         = kind_reg;
        status.step_zero    = step_reg == '0;
        status.div_done     = div_done;
        status.out_free     = !out_valid_reg || res_ready;
    end

    assign res_valid      = out_valid_reg;
    assign smoothed_value = out_value_reg;
    assign max_change     = out_chg_reg;
    assign frame_last     = out_last_reg;

endmodule

// ----- hdl/tahs_ctrl.sv -----
// sequencer that steps one item through reads, divisions and output
module tahs_ctrl
    import tahs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  tahs_status_t status,
    output tahs_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.drain)
                    state_next = status.pending_zero ? ST_IDLE : ST_RD_C;
                else if (status.kind)
                    state_next = ST_IDLE;
                else if (status.row_nonzero)
                    state_next = ST_RD_C;
                else
                    state_next = ST_WRITE;
            end
            ST_RD_C:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CENTER;
                state_next = ST_RD_L;
            end
            ST_RD_L:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LEFT;
                state_next = ST_RD_R;
            end
            ST_RD_R:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_RIGHT;
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ABOVE;
                state_next = status.step_zero ? ST_SUM : ST_BAND_GO;
            end
            ST_BAND_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_BAND;
                state_next    = ST_BAND_WAIT;
            end
            ST_BAND_WAIT:
            begin
                cmd.div_op = DIV_BAND;
                if (status.div_done)
                begin
                    cmd.cap_band = 1'b1;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.cap_sum = 1'b1;
                state_next  = ST_CHG_GO;
            end
            ST_CHG_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_CHG;
                state_next    = ST_CHG_WAIT;
            end
            ST_CHG_WAIT:
            begin
                cmd.div_op = DIV_CHG;
                if (status.div_done)
                begin
                    cmd.cap_chg = 1'b1;
                    state_next  = ST_Q_GO;
                end
            end
            ST_Q_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_QUANT;
                state_next    = ST_Q_WAIT;
            end
            ST_Q_WAIT:
            begin
                cmd.div_op = DIV_QUANT;
                if (status.div_done)
                begin
                    cmd.cap_q  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.cap_fin = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/terrace_aware_heightmap_smoothing.sv -----
// Four-neighbor heightmap smoothing with terrace bands, one sample request at a time.
// Samples of the first row are only stored. Every other request that yields a result
// takes four row store reads over its single read port, then the shared 40-step
// bit-serial divider runs for the terrace band of the center (skipped with terracing
// off), the change and the final quantization, which dominate. Results lag one row;
// after the frame, send grid_width drain requests. A finished result waits in the
// output register while the next request is taken. A write to grid width, height
// or terrace step restarts the frame; the row store contents are kept.
module terrace_aware_heightmap_smoothing
    import tahs_pkg::*;
#(
    parameter int MAX_WIDTH = TAHS_MAX_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    tahs_sample_if.sink   samples,
    tahs_result_if.source results,
    tahs_cfg_if.sink      cfg
);

    tahs_cmd_t    cmd;
    tahs_status_t status;

    assign cfg.ready = 1'b1;

    tahs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (samples.valid),
        .item_ready (samples.ready),
        .status     (status),
        .cmd        (cmd)
    );

    tahs_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (samples.kind),
        .height_value   (samples.height_value),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .res_ready      (results.ready),
        .res_valid      (results.valid),
        .smoothed_value (results.smoothed_value),
        .max_change     (results.max_change),
        .frame_last     (results.frame_last)
    );

endmodule
